[design/pmu_pkg.sv]
// Shared types, register indexes and a saturation helper function for the particle motion update block.
package pmu_pkg;

  localparam int DataW = 32;
  localparam int DirW = 16;
  localparam int SlotW = 6;
  localparam int SumW = 52;
  localparam logic [15:0] DirOne = 16'd16384;
  localparam int SqrtIters = 32;
  localparam int DivIters = 45;

  localparam logic [2:0] REG_MODE = 3'd0;
  localparam logic [2:0] REG_LOOP = 3'd1;
  localparam logic [2:0] REG_PIVOT_X = 3'd2;
  localparam logic [2:0] REG_PIVOT_Y = 3'd3;
  localparam logic [2:0] REG_PIVOT_Z = 3'd4;
  localparam logic [2:0] REG_COUNT = 3'd5;

  localparam logic [1:0] MODE_DROP = 2'd0;
  localparam logic [1:0] MODE_SPREAD = 2'd1;
  localparam logic [1:0] MODE_GATHER = 2'd2;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_NORM,
    OP_SQUARE,
    OP_ACC,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_END,
    OP_LOAD_WR,
    OP_READ,
    OP_STEP_MUL,
    OP_MOVE_MUL,
    OP_UPDATE
  } op_t;

  typedef struct packed {
    op_t op;
    logic [1:0] axis;
  } dp_cmd_t;

  typedef struct packed {
    logic iter_last;
    logic count_zero;
    logic last_item;
  } dp_stat_t;

  typedef struct packed {
    logic [1:0] mode;
    logic loop_en;
    logic signed [31:0] pivot_x;
    logic signed [31:0] pivot_y;
    logic signed [31:0] pivot_z;
    logic [6:0] count;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] cur_x;
    logic signed [31:0] cur_y;
    logic signed [31:0] cur_z;
    logic [31:0] elapsed;
    logic [31:0] life;
    logic [31:0] speed;
    logic signed [31:0] org_x;
    logic signed [31:0] org_y;
    logic signed [31:0] org_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
  } particle_t;

  function automatic logic signed [31:0] sat32(input logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] hi;
    logic signed [SumW-1:0] lo;
    hi = SumW'(64'sd2147483647);
    lo = -SumW'(64'sd2147483648);
    if (v > hi) begin
      return 32'sh7FFFFFFF;
    end else if (v < lo) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

[design/pmu_ram.sv]
// Generic single-port-write, registered-read RAM.
module pmu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/pmu_ctrl.sv]
// Controller state machine that sequences loads and tick runs.
module pmu_ctrl
  import pmu_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  logic     cmd,
  input  dp_stat_t stat,
  output logic     busy,
  output dp_cmd_t  dcmd
);

  typedef enum logic [13:0] {
    S_IDLE      = 14'b00000000000001,
    S_NORM      = 14'b00000000000010,
    S_SQ        = 14'b00000000000100,
    S_ACC       = 14'b00000000001000,
    S_SQRT_INIT = 14'b00000000010000,
    S_SQRT      = 14'b00000000100000,
    S_DIV_INIT  = 14'b00000001000000,
    S_DIV       = 14'b00000010000000,
    S_DIV_END   = 14'b00000100000000,
    S_LOAD_WR   = 14'b00001000000000,
    S_TK_READ   = 14'b00010000000000,
    S_TK_MUL    = 14'b00100000000000,
    S_TK_MOVE   = 14'b01000000000000,
    S_TK_UPD    = 14'b10000000000000
  } state_t;

  state_t state, state_next;
  logic [1:0] axis, axis_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      axis <= 2'd0;
    end else begin
      state <= state_next;
      axis <= axis_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    axis_next = axis;
    dcmd.op = OP_NONE;
    dcmd.axis = axis;
    case (state)
      S_IDLE: begin
        if (start) begin
          dcmd.op = OP_CAPTURE;
          state_next = (cmd == CMD_LOAD) ? S_NORM : S_TK_READ;
        end
      end
      S_NORM: begin
        dcmd.op = OP_NORM;
        axis_next = 2'd0;
        state_next = S_SQ;
      end
      S_SQ: begin
        dcmd.op = OP_SQUARE;
        axis_next = axis + 2'd1;
        if (axis == 2'd2) begin
          state_next = S_ACC;
        end
      end
      S_ACC: begin
        dcmd.op = OP_ACC;
        state_next = S_SQRT_INIT;
      end
      S_SQRT_INIT: begin
        dcmd.op = OP_SQRT_INIT;
        state_next = S_SQRT;
      end
      S_SQRT: begin
        dcmd.op = OP_SQRT_STEP;
        if (stat.iter_last) begin
          axis_next = 2'd0;
          state_next = S_DIV_INIT;
        end
      end
      S_DIV_INIT: begin
        dcmd.op = OP_DIV_INIT;
        state_next = S_DIV;
      end
      S_DIV: begin
        dcmd.op = OP_DIV_STEP;
        if (stat.iter_last) begin
          state_next = S_DIV_END;
        end
      end
      S_DIV_END: begin
        dcmd.op = OP_DIV_END;
        axis_next = axis + 2'd1;
        state_next = (axis == 2'd2) ? S_LOAD_WR : S_DIV_INIT;
      end
      S_LOAD_WR: begin
        dcmd.op = OP_LOAD_WR;
        state_next = S_IDLE;
      end
      S_TK_READ: begin
        if (stat.count_zero) begin
          state_next = S_IDLE;
        end else begin
          dcmd.op = OP_READ;
          state_next = S_TK_MUL;
        end
      end
      S_TK_MUL: begin
        dcmd.op = OP_STEP_MUL;
        axis_next = 2'd0;
        state_next = S_TK_MOVE;
      end
      S_TK_MOVE: begin
        dcmd.op = OP_MOVE_MUL;
        axis_next = axis + 2'd1;
        if (axis == 2'd2) begin
          state_next = S_TK_UPD;
        end
      end
      S_TK_UPD: begin
        dcmd.op = OP_UPDATE;
        state_next = stat.last_item ? S_IDLE : S_TK_READ;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[design/pmu_dpath.sv]
// Datapath with the particle table, direction unit and per-particle update logic.
module pmu_dpath
  import pmu_pkg::*;
#(
  parameter int MAX_PARTICLES = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  dp_cmd_t             dcmd,
  output dp_stat_t            stat,
  input  cfg_t                cfg,
  input  logic [SlotW-1:0]    slot,
  input  logic signed [31:0]  start_x,
  input  logic signed [31:0]  start_y,
  input  logic signed [31:0]  start_z,
  input  logic [31:0]         lifetime,
  input  logic [31:0]         speed,
  input  logic [31:0]         time_step,
  output logic                out_valid,
  output logic [SlotW-1:0]    out_slot,
  output logic signed [31:0]  pos_x,
  output logic signed [31:0]  pos_y,
  output logic signed [31:0]  pos_z,
  output logic [31:0]         elapsed,
  output logic                last
);

  localparam int IW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int CW = $clog2(MAX_PARTICLES + 1);
  localparam int EW = (IW > SlotW) ? IW : SlotW;

  logic [SlotW-1:0] slot_r;
  logic signed [31:0] sx_r, sy_r, sz_r;
  logic [31:0] life_r, speed_r, dt_r;
  logic signed [32:0] d_r [3];
  logic [30:0] a_r [3];
  logic neg_r [3];
  logic [63:0] prod_r, acc_r;
  logic [63:0] src_r;
  logic [35:0] rem_r;
  logic [31:0] root_r;
  logic [44:0] num_r, quo_r;
  logic [32:0] drem_r;
  logic [5:0] cnt_r;
  logic signed [15:0] dir_r [3];
  logic [CW-1:0] n_r;
  logic [IW-1:0] idx_r;
  logic [63:0] sprod_r;
  logic [62:0] mprod_r [3];

  particle_t rd_rec, wr_rec;
  logic ram_we, ram_re;
  logic [IW-1:0] ram_waddr;

  logic [32:0] ab [3];
  logic [32:0] mx;
  logic [1:0] sh;
  logic [35:0] sq_t, sq_trial;
  logic [32:0] dv_t;
  logic [44:0] q_sel;
  logic [15:0] q_clamp;
  logic signed [15:0] dsel;
  logic [14:0] dmag;
  logic [47:0] step;
  logic [32:0] el_sum;
  logic [31:0] el_sat;
  logic restart;
  logic signed [SumW-1:0] pos_old [3];
  logic signed [SumW-1:0] mv [3];
  logic signed [SumW-1:0] pos_sum [3];
  logic signed [31:0] pos_new [3];
  logic signed [15:0] rdir [3];
  logic signed [31:0] rcur [3];
  logic signed [31:0] rorg [3];
  logic [EW-1:0] slot_ext, idx_ext;
  logic slot_ok;

  pmu_ram #(.WIDTH($bits(particle_t)), .DEPTH(MAX_PARTICLES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_rec),
    .re    (ram_re),
    .raddr (idx_r),
    .rdata (rd_rec)
  );

  assign slot_ext = EW'(slot_r);
  assign idx_ext = EW'(idx_r);
  assign slot_ok = (32'(slot_r) < 32'(MAX_PARTICLES));

  assign stat.iter_last = (cnt_r == 6'd1);
  assign stat.count_zero = (n_r == '0);
  assign stat.last_item = (32'(idx_r) + 32'd1 == 32'(n_r));

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ab[k] = d_r[k][32] ? 33'(-d_r[k]) : 33'(d_r[k]);
    end
    mx = ab[0];
    if (ab[1] > mx) begin
      mx = ab[1];
    end
    if (ab[2] > mx) begin
      mx = ab[2];
    end
    if (mx[32]) begin
      sh = 2'd2;
    end else if (mx[31]) begin
      sh = 2'd1;
    end else begin
      sh = 2'd0;
    end

    sq_t = {rem_r[33:0], src_r[63:62]};
    sq_trial = {2'b00, root_r, 2'b01};
    dv_t = {drem_r[31:0], num_r[44]};

    q_sel = (root_r == '0) ? '0 : quo_r;
    q_clamp = (q_sel > 45'(DirOne)) ? DirOne : q_sel[15:0];

    case (dcmd.axis)
      2'd0: dsel = rd_rec.dir_x;
      2'd1: dsel = rd_rec.dir_y;
      default: dsel = rd_rec.dir_z;
    endcase
    dmag = dsel[15] ? 15'(-dsel) : dsel[14:0];
    step = sprod_r[63:16];

    rdir[0] = rd_rec.dir_x;
    rdir[1] = rd_rec.dir_y;
    rdir[2] = rd_rec.dir_z;
    rcur[0] = rd_rec.cur_x;
    rcur[1] = rd_rec.cur_y;
    rcur[2] = rd_rec.cur_z;
    rorg[0] = rd_rec.org_x;
    rorg[1] = rd_rec.org_y;
    rorg[2] = rd_rec.org_z;

    el_sum = {1'b0, rd_rec.elapsed} + {1'b0, dt_r};
    el_sat = el_sum[32] ? 32'hFFFFFFFF : el_sum[31:0];
    restart = cfg.loop_en && (el_sat >= rd_rec.life);

    for (int k = 0; k < 3; k++) begin
      pos_old[k] = SumW'(rcur[k]);
      mv[k] = rdir[k][15] ? -$signed({3'b000, mprod_r[k][62:14]})
                          : $signed({3'b000, mprod_r[k][62:14]});
      case (cfg.mode)
        MODE_DROP: begin
          pos_sum[k] = (k == 1) ? pos_old[k] - $signed({4'b0000, step}) : pos_old[k];
        end
        MODE_SPREAD: pos_sum[k] = pos_old[k] - mv[k];
        MODE_GATHER: pos_sum[k] = pos_old[k] + mv[k];
        default: pos_sum[k] = pos_old[k];
      endcase
      pos_new[k] = sat32(pos_sum[k]);
      if (restart && ((k == 1) || (cfg.mode != MODE_DROP))) begin
        pos_new[k] = rorg[k];
      end
    end

    ram_we = 1'b0;
    ram_re = (dcmd.op == OP_READ);
    ram_waddr = idx_r;
    wr_rec = rd_rec;
    if (dcmd.op == OP_LOAD_WR) begin
      ram_we = slot_ok;
      ram_waddr = slot_ext[IW-1:0];
      wr_rec.cur_x = sx_r;
      wr_rec.cur_y = sy_r;
      wr_rec.cur_z = sz_r;
      wr_rec.org_x = sx_r;
      wr_rec.org_y = sy_r;
      wr_rec.org_z = sz_r;
      wr_rec.elapsed = '0;
      wr_rec.life = life_r;
      wr_rec.speed = speed_r;
      wr_rec.dir_x = dir_r[0];
      wr_rec.dir_y = dir_r[1];
      wr_rec.dir_z = dir_r[2];
    end else if (dcmd.op == OP_UPDATE) begin
      ram_we = 1'b1;
      wr_rec.cur_x = pos_new[0];
      wr_rec.cur_y = pos_new[1];
      wr_rec.cur_z = pos_new[2];
      wr_rec.elapsed = restart ? '0 : el_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cnt_r <= '0;
      n_r <= '0;
      idx_r <= '0;
    end else begin
      out_valid <= (dcmd.op == OP_UPDATE);
      case (dcmd.op)
        OP_CAPTURE: begin
          idx_r <= '0;
          n_r <= (32'(cfg.count) > 32'(MAX_PARTICLES)) ? CW'(MAX_PARTICLES)
                                                       : CW'(cfg.count);
        end
        OP_SQRT_INIT: cnt_r <= 6'(SqrtIters);
        OP_DIV_INIT: cnt_r <= 6'(DivIters);
        OP_SQRT_STEP, OP_DIV_STEP: cnt_r <= cnt_r - 6'd1;
        OP_UPDATE: idx_r <= idx_r + IW'(1);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (dcmd.op)
      OP_CAPTURE: begin
        slot_r <= slot;
        sx_r <= start_x;
        sy_r <= start_y;
        sz_r <= start_z;
        life_r <= lifetime;
        speed_r <= speed;
        dt_r <= time_step;
        d_r[0] <= 33'(cfg.pivot_x) - 33'(start_x);
        d_r[1] <= 33'(cfg.pivot_y) - 33'(start_y);
        d_r[2] <= 33'(cfg.pivot_z) - 33'(start_z);
      end
      OP_NORM: begin
        for (int k = 0; k < 3; k++) begin
          a_r[k] <= 31'(ab[k] >> sh);
          neg_r[k] <= d_r[k][32];
        end
        prod_r <= '0;
        acc_r <= '0;
      end
      OP_SQUARE: begin
        prod_r <= 64'(a_r[dcmd.axis]) * 64'(a_r[dcmd.axis]);
        acc_r <= acc_r + prod_r;
      end
      OP_ACC: acc_r <= acc_r + prod_r;
      OP_SQRT_INIT: begin
        src_r <= acc_r;
        rem_r <= '0;
        root_r <= '0;
      end
      OP_SQRT_STEP: begin
        src_r <= {src_r[61:0], 2'b00};
        if (sq_t >= sq_trial) begin
          rem_r <= sq_t - sq_trial;
          root_r <= {root_r[30:0], 1'b1};
        end else begin
          rem_r <= sq_t;
          root_r <= {root_r[30:0], 1'b0};
        end
      end
      OP_DIV_INIT: begin
        num_r <= {a_r[dcmd.axis], 14'd0};
        drem_r <= '0;
        quo_r <= '0;
      end
      OP_DIV_STEP: begin
        num_r <= {num_r[43:0], 1'b0};
        if (dv_t >= {1'b0, root_r}) begin
          drem_r <= dv_t - {1'b0, root_r};
          quo_r <= {quo_r[43:0], 1'b1};
        end else begin
          drem_r <= dv_t;
          quo_r <= {quo_r[43:0], 1'b0};
        end
      end
      OP_DIV_END: begin
        dir_r[dcmd.axis] <= neg_r[dcmd.axis] ? -$signed(q_clamp) : $signed(q_clamp);
      end
      OP_STEP_MUL: sprod_r <= 64'(rd_rec.speed) * 64'(dt_r);
      OP_MOVE_MUL: mprod_r[dcmd.axis] <= 63'(dmag) * 63'(step);
      OP_UPDATE: begin
        out_slot <= idx_ext[SlotW-1:0];
        pos_x <= pos_new[0];
        pos_y <= pos_new[1];
        pos_z <= pos_new[2];
        elapsed <= restart ? '0 : el_sat;
        last <= stat.last_item;
      end
      default: begin
      end
    endcase
  end

endmodule

[design/particle_motion_update_top.sv]
// Top level of the particle motion update block with its register port.
// A load word runs a 32-step square root and three 45-step divisions.
// A tick word walks N particles, N being the count register capped at MAX_PARTICLES; none when it is zero.
// Each particle needs a read, a step multiply, three move multiplies and a write-back.
// Each particle's result is flagged on out_valid, registered from its write-back.
// The receiver cannot stall; rst is synchronous and clears control and registers, not the table.
module particle_motion_update_top
  import pmu_pkg::*;
#(
  parameter int MAX_PARTICLES = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               cmd,
  input  logic [5:0]         slot,
  input  logic signed [31:0] start_x,
  input  logic signed [31:0] start_y,
  input  logic signed [31:0] start_z,
  input  logic [31:0]        lifetime,
  input  logic [31:0]        speed,
  input  logic [31:0]        time_step,
  output logic               out_valid,
  output logic [5:0]         out_slot,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] pos_z,
  output logic [31:0]        elapsed,
  output logic               last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t cfg;
  dp_cmd_t dcmd;
  dp_stat_t stat;
  logic [2:0] reg_idx;

  assign pready = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode <= MODE_DROP;
      cfg.loop_en <= 1'b0;
      cfg.pivot_x <= '0;
      cfg.pivot_y <= '0;
      cfg.pivot_z <= '0;
      cfg.count <= 7'd64;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_MODE: cfg.mode <= pwdata[1:0];
        REG_LOOP: cfg.loop_en <= pwdata[0];
        REG_PIVOT_X: cfg.pivot_x <= pwdata;
        REG_PIVOT_Y: cfg.pivot_y <= pwdata;
        REG_PIVOT_Z: cfg.pivot_z <= pwdata;
        REG_COUNT: cfg.count <= pwdata[6:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MODE: prdata = {30'd0, cfg.mode};
      REG_LOOP: prdata = {31'd0, cfg.loop_en};
      REG_PIVOT_X: prdata = cfg.pivot_x;
      REG_PIVOT_Y: prdata = cfg.pivot_y;
      REG_PIVOT_Z: prdata = cfg.pivot_z;
      REG_COUNT: prdata = {25'd0, cfg.count};
      default: prdata = '0;
    endcase
  end

  pmu_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .stat  (stat),
    .busy  (busy),
    .dcmd  (dcmd)
  );

  pmu_dpath #(.MAX_PARTICLES(MAX_PARTICLES)) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .dcmd      (dcmd),
    .stat      (stat),
    .cfg       (cfg),
    .slot      (slot),
    .start_x   (start_x),
    .start_y   (start_y),
    .start_z   (start_z),
    .lifetime  (lifetime),
    .speed     (speed),
    .time_step (time_step),
    .out_valid (out_valid),
    .out_slot  (out_slot),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .pos_z     (pos_z),
    .elapsed   (elapsed),
    .last      (last)
  );

`ifndef NO_ASSERTIONS
  a_mid_run_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last) |-> busy)
    else $error("result inside a run while the block is idle");

  a_accept_quiet: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !out_valid)
    else $error("result right after a word was accepted");

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last) |=> !out_valid)
    else $error("result follows the last word of a run");
`endif

endmodule
